/* rtl/fsrlin_pkg.sv */
// Shared constants, tables and types of the FSR ADC to force linearizer.
`timescale 1ns / 1ps
`default_nettype none

package fsrlin_pkg;

	// Number of points in the resistance to force falloff table.
	localparam int TABLE_POINTS = 10;

	// Index width into the falloff table.
	localparam int SEG_W = $clog2(TABLE_POINTS);

	// Field widths.
	localparam int CODE_W  = 12;
	localparam int FORCE_W = 11;
	localparam int SUM_W   = 16;
	localparam int RES_W   = 24;
	localparam int TRES_W  = 23;

	// Divider widths: a 32 bit dividend over a divisor of table-span width.
	localparam int DVD_W  = 32;
	localparam int DVSR_W = 23;
	localparam int CNT_W  = $clog2(DVD_W);

	// Resistance in kOhm, Q8.16: floor(RK_NUM / code) - RK_OFS, clamped.
	localparam logic [DVD_W-1:0] RK_NUM  = 32'd2405181686;
	localparam logic [DVD_W-1:0] RK_OFS  = 32'd445645;
	localparam logic [RES_W-1:0] R_SAT   = 24'hFFFFFF;
	localparam logic [SUM_W-1:0] SUM_MAX = 16'hFFFF;

	// Resistance points in kOhm, Q7.16, descending.
	localparam logic [TRES_W-1:0] TAB_RES [TABLE_POINTS] = '{
		23'd6553600, 23'd2621440, 23'd1310720, 23'd655360, 23'd327680,
		23'd229376, 23'd183501, 23'd157286, 23'd117965, 23'd98304
	};

	// Force points in grams, ascending.
	localparam logic [FORCE_W-1:0] TAB_FORCE [TABLE_POINTS] = '{
		11'd20, 11'd50, 11'd100, 11'd200, 11'd400,
		11'd600, 11'd800, 11'd1000, 11'd1500, 11'd2000
	};

	// Status of the shared divider as seen by the sequencer.
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

`default_nettype wire

/* rtl/fsrlin_div.sv */
// Shared restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module fsrlin_div (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	input  wire logic [fsrlin_pkg::DVD_W-1:0]      dividend,
	input  wire logic [fsrlin_pkg::DVSR_W-1:0]     divisor,
	output logic      [fsrlin_pkg::DVD_W-1:0]      quotient,
	output fsrlin_pkg::div_stat_t                  stat
);

	logic [fsrlin_pkg::DVSR_W-1:0] rem_q;
	logic [fsrlin_pkg::DVSR_W-1:0] dvsr_q;
	logic [fsrlin_pkg::DVD_W-1:0]  quo_q;
	logic [fsrlin_pkg::CNT_W-1:0]  cnt_q;
	logic                          busy_q;
	logic                          done_q;
	logic [fsrlin_pkg::DVSR_W:0]   trial;
	logic [fsrlin_pkg::DVSR_W:0]   diff;
	logic                          fits;

	// Shift the next dividend bit into the partial remainder and try a subtract.
	always_comb begin
		trial = {rem_q, quo_q[fsrlin_pkg::DVD_W-1]};
		diff  = trial - {1'b0, dvsr_q};
		fits  = trial >= {1'b0, dvsr_q};
	end

	// Control state of the iteration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == fsrlin_pkg::CNT_W'(fsrlin_pkg::DVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder and quotient datapath.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			quo_q  <= dividend;
			dvsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[fsrlin_pkg::DVSR_W-1:0] : trial[fsrlin_pkg::DVSR_W-1:0];
			quo_q <= {quo_q[fsrlin_pkg::DVD_W-2:0], fits};
		end
	end

	assign quotient  = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

`default_nettype wire

/* rtl/fsr_adc_to_force_linearizer_unit.sv */
// Top level of the FSR ADC to force linearizer: sequencer, output word and frame total.
//
// Usage: each input word on s_* carries one 12-bit divider ADC code, with s_tlast
// marking the last channel of a frame. Each word gives exactly one output word on
// m_*: the interpolated force in grams, a max flag, and on the frame's last word
// (m_tlast high) the saturating frame total and its max flag.
// A code inside the table range takes two 32-step passes through the shared
// bit-serial divider (resistance, then interpolation) plus sequencing before it reaches
// the output register. Codes at or beyond the table ends take only the first pass, and
// a zero code takes none. One word is in work at a time, and the next word is taken in
// the cycle after a result is stored; s_tready is high only while the sequencer idles.
// The output register holds a finished word while m_tready is low; the sequencer
// then waits with its next result and accepts no new word until it has been stored.
// Reset clears the sequencer, the output valid, the frame total and its max flag.
`timescale 1ns / 1ps
`default_nettype none

module fsr_adc_to_force_linearizer_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// s_tdata: [11:0] adc_code, [15:12] zero
	input  wire logic [15:0] s_tdata,
	input  wire logic        s_tlast,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// m_tdata: [10:0] force_grams, [11] force_at_max, [27:12] frame_total,
	// [28] total_at_max, [31:29] zero
	output logic      [31:0] m_tdata,
	output logic             m_tlast,
	output logic             m_tvalid,
	input  wire logic        m_tready
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_DIV1  = 3'd1;
	localparam logic [2:0] S_CLASS = 3'd2;
	localparam logic [2:0] S_MUL   = 3'd3;
	localparam logic [2:0] S_DIV2  = 3'd4;
	localparam logic [2:0] S_FIN   = 3'd5;

	logic [2:0]                              state_q;
	logic                                    last_q;
	logic [fsrlin_pkg::RES_W-1:0]            res_q;
	logic [fsrlin_pkg::SEG_W-1:0]            seg_q;
	logic [fsrlin_pkg::FORCE_W-1:0]          force_q;
	logic                                    at_max_q;
	logic [fsrlin_pkg::SUM_W-1:0]            sum_q;
	logic                                    sat_q;
	logic [31:0]                             out_data_q;
	logic                                    out_last_q;
	logic                                    out_valid_q;

	logic                                    in_fire;
	logic                                    out_load;
	logic [fsrlin_pkg::CODE_W-1:0]           code;
	logic                                    div_start;
	logic [fsrlin_pkg::DVD_W-1:0]            div_dvd;
	logic [fsrlin_pkg::DVSR_W-1:0]           div_dvsr;
	logic [fsrlin_pkg::DVD_W-1:0]            div_quo;
	fsrlin_pkg::div_stat_t                   div_stat;
	logic [fsrlin_pkg::DVD_W-1:0]            res_diff;
	logic [fsrlin_pkg::RES_W-1:0]            res_next;
	logic [fsrlin_pkg::SEG_W:0]              above_cnt;
	logic [fsrlin_pkg::SEG_W-1:0]            seg_hi;
	logic [fsrlin_pkg::FORCE_W-1:0]          force_df;
	logic [fsrlin_pkg::TRES_W-1:0]           res_off;
	logic [fsrlin_pkg::FORCE_W+fsrlin_pkg::TRES_W-1:0] product;
	logic [fsrlin_pkg::SUM_W:0]              sum_add;
	logic [fsrlin_pkg::SUM_W-1:0]            sum_next;
	logic                                    sat_next;

	assign code     = s_tdata[fsrlin_pkg::CODE_W-1:0];
	assign s_tready = (state_q == S_IDLE);
	assign in_fire  = s_tvalid && s_tready;
	assign out_load = (state_q == S_FIN) && (!out_valid_q || m_tready);

	// Resistance from the first quotient, clamped at zero and at full scale.
	always_comb begin
		res_diff = div_quo - fsrlin_pkg::RK_OFS;
		if (div_quo <= fsrlin_pkg::RK_OFS) begin
			res_next = '0;
		end else if (res_diff > {8'd0, fsrlin_pkg::R_SAT}) begin
			res_next = fsrlin_pkg::R_SAT;
		end else begin
			res_next = res_diff[fsrlin_pkg::RES_W-1:0];
		end
	end

	// Segment search: count the table points that lie above the resistance.
	always_comb begin
		above_cnt = '0;
		for (int k = 0; k < fsrlin_pkg::TABLE_POINTS; k++) begin
			above_cnt = above_cnt + {{fsrlin_pkg::SEG_W{1'b0}},
				({1'b0, fsrlin_pkg::TAB_RES[k]} > res_q)};
		end
	end

	// Interpolation operands: force step times distance below the upper point.
	always_comb begin
		seg_hi   = seg_q + 1'b1;
		force_df = fsrlin_pkg::TAB_FORCE[seg_hi] - fsrlin_pkg::TAB_FORCE[seg_q];
		res_off  = fsrlin_pkg::TAB_RES[seg_q] - res_q[fsrlin_pkg::TRES_W-1:0];
		product  = force_df * res_off;
	end

	// Divider operands for the two passes.
	always_comb begin
		div_start = 1'b0;
		div_dvd   = fsrlin_pkg::RK_NUM;
		div_dvsr  = {{(fsrlin_pkg::DVSR_W - fsrlin_pkg::CODE_W){1'b0}}, code};
		if (state_q == S_MUL) begin
			div_start = 1'b1;
			div_dvd   = product[fsrlin_pkg::DVD_W-1:0];
			div_dvsr  = fsrlin_pkg::TAB_RES[seg_q] - fsrlin_pkg::TAB_RES[seg_hi];
		end else if (in_fire && (code != '0)) begin
			div_start = 1'b1;
		end
	end

	fsrlin_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvsr),
		.quotient (div_quo),
		.stat     (div_stat)
	);

	// Sequencer over the shared divider.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						state_q <= (code == '0) ? S_FIN : S_DIV1;
					end
				end
				S_DIV1: begin
					if (div_stat.done) begin
						state_q <= S_CLASS;
					end
				end
				S_CLASS: begin
					if (res_q >= {1'b0, fsrlin_pkg::TAB_RES[0]} ||
					    res_q <= {1'b0, fsrlin_pkg::TAB_RES[fsrlin_pkg::TABLE_POINTS-1]}) begin
						state_q <= S_FIN;
					end else begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					state_q <= S_DIV2;
				end
				S_DIV2: begin
					if (div_stat.done) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Working registers of the item in flight.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			last_q   <= s_tlast;
			force_q  <= '0;
			at_max_q <= 1'b0;
		end
		if (state_q == S_DIV1 && div_stat.done) begin
			res_q <= res_next;
		end
		if (state_q == S_CLASS) begin
			seg_q <= above_cnt[fsrlin_pkg::SEG_W-1:0] - 1'b1;
			if (res_q <= {1'b0, fsrlin_pkg::TAB_RES[fsrlin_pkg::TABLE_POINTS-1]}) begin
				at_max_q <= 1'b1;
			end
		end
		if (state_q == S_DIV2 && div_stat.done) begin
			force_q <= fsrlin_pkg::TAB_FORCE[seg_q] + div_quo[fsrlin_pkg::FORCE_W-1:0];
		end
	end

	// Frame total update for the finished item.
	always_comb begin
		sum_add  = {1'b0, sum_q} + {{(fsrlin_pkg::SUM_W + 1 - fsrlin_pkg::FORCE_W){1'b0}}, force_q};
		sat_next = sat_q || at_max_q;
		if (at_max_q) begin
			sum_next = sum_q;
		end else if (sum_add[fsrlin_pkg::SUM_W]) begin
			sum_next = fsrlin_pkg::SUM_MAX;
		end else begin
			sum_next = sum_add[fsrlin_pkg::SUM_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			sat_q <= 1'b0;
		end else if (out_load) begin
			sum_q <= last_q ? '0 : sum_next;
			sat_q <= last_q ? 1'b0 : sat_next;
		end
	end

	// Output word register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_last_q <= last_q;
			out_data_q <= {3'd0,
				last_q && sat_next,
				(last_q && !sat_next) ? sum_next : {fsrlin_pkg::SUM_W{1'b0}},
				at_max_q,
				force_q};
		end
	end

	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;
	assign m_tvalid = out_valid_q;

`ifndef ASSERT_OFF
	// The divider finishes only while the sequencer waits for it.
	assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> (state_q == S_DIV1 || state_q == S_DIV2))
		else $error("divider finished outside a divide state");

	// A force at max is reported as zero grams.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[11]) |-> (m_tdata[10:0] == '0))
		else $error("force at max with nonzero grams");

	// A stored result shows up as a valid output word in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (m_tvalid && state_q == S_IDLE))
		else $error("finished word not presented");

	// No new word is taken while the divider is still busy.
	assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.busy |-> !s_tready)
		else $error("input accepted during a divide");
`endif

endmodule

`default_nettype wire

/* tb/fsr_adc_to_force_linearizer_unit_tb.sv */
// Self-checking testbench of the FSR ADC to force linearizer with a predictor and scoreboard.
`timescale 1ns / 1ps

module fsr_adc_to_force_linearizer_unit_tb;

	// Falloff table: resistance in kOhm Q7.16 descending, force in grams ascending.
	localparam int N_PTS = 10;
	localparam logic [22:0] RES_PTS [N_PTS] = '{
		23'd6553600, 23'd2621440, 23'd1310720, 23'd655360, 23'd327680,
		23'd229376, 23'd183501, 23'd157286, 23'd117965, 23'd98304
	};
	localparam logic [10:0] GRAM_PTS [N_PTS] = '{
		11'd20, 11'd50, 11'd100, 11'd200, 11'd400,
		11'd600, 11'd800, 11'd1000, 11'd1500, 11'd2000
	};
	// Divider numerator and offset of the resistance formula, Q8.16.
	localparam logic [31:0] DIVIDER_NUM = 32'd2405181686;
	localparam logic [31:0] DIVIDER_OFS = 32'd445645;
	localparam logic [23:0] RES_CEIL    = 24'hFFFFFF;
	localparam int MAX_GAP       = 18;
	localparam int HOLD_CYCLES   = 600;
	localparam int IDLE_LIMIT    = 4000;
	localparam int DRAIN_CYCLES  = 200;

	// One expected output word.
	typedef struct packed {
		logic [10:0] grams;
		logic        at_max;
		logic [15:0] total;
		logic        total_max;
		logic        total_valid;
	} force_word_t;

	logic        clk;
	logic        arst_n;
	logic [15:0] s_tdata;
	logic        s_tlast;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] m_tdata;
	logic        m_tlast;
	logic        m_tvalid;
	logic        m_tready;

	force_word_t expected_words [$];
	logic [15:0] frame_sum;
	logic        frame_hit_max;
	int unsigned mismatch_count;
	int unsigned words_sent;
	int unsigned idle_cycles;
	bit          gaps_on;
	bit          hold_req;

	fsr_adc_to_force_linearizer_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready)
	);

	// Free-running clock, 8 ns period.
	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Resistance from the code, then force by interpolation over the falloff table.
	function automatic logic [10:0] force_of_code(input logic [11:0] code,
		output logic hit_max);
		logic [31:0] quot;
		logic [23:0] res;
		logic [63:0] df;
		logic [63:0] dr;
		logic [63:0] den;
		logic [10:0] grams;
		logic        found;
		hit_max = 1'b0;
		grams   = '0;
		found   = 1'b0;
		if (code == 12'd0) begin
			res = RES_CEIL;
		end else begin
			quot = DIVIDER_NUM / {20'd0, code};
			if (quot <= DIVIDER_OFS) begin
				res = '0;
			end else begin
				quot = quot - DIVIDER_OFS;
				res  = (quot > {8'd0, RES_CEIL}) ? RES_CEIL : quot[23:0];
			end
		end
		if (res >= {1'b0, RES_PTS[0]}) begin
			grams = '0;
		end else if (res <= {1'b0, RES_PTS[N_PTS-1]}) begin
			hit_max = 1'b1;
		end else begin
			for (int k = 0; k < N_PTS - 1; k++) begin
				if (!found && res <= {1'b0, RES_PTS[k]} && res >= {1'b0, RES_PTS[k+1]}) begin
					df    = GRAM_PTS[k+1] - GRAM_PTS[k];
					dr    = RES_PTS[k] - res;
					den   = RES_PTS[k] - RES_PTS[k+1];
					grams = GRAM_PTS[k] + 11'((df * dr) / den);
					found = 1'b1;
				end
			end
			if (!found)
				hit_max = 1'b1;
		end
		return grams;
	endfunction

	// Works out the output word of an accepted input word and updates the frame total.
	task automatic account_word(input logic [11:0] code, input logic last);
		force_word_t w;
		logic        hit_max;
		logic [16:0] wide_sum;
		w.grams  = force_of_code(code, hit_max);
		w.at_max = hit_max;
		if (hit_max) begin
			frame_hit_max = 1'b1;
		end else begin
			wide_sum  = frame_sum + w.grams;
			frame_sum = wide_sum[16] ? 16'hFFFF : wide_sum[15:0];
		end
		w.total_valid = last;
		if (last) begin
			w.total       = frame_hit_max ? 16'd0 : frame_sum;
			w.total_max   = frame_hit_max;
			frame_sum     = '0;
			frame_hit_max = 1'b0;
		end else begin
			w.total     = '0;
			w.total_max = 1'b0;
		end
		expected_words.push_back(w);
	endtask

	// Offers one word, after a random gap while gaps are switched on, and waits until it is taken.
	task automatic send_word(input logic [11:0] code, input logic last);
		int gap;
		gap = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tdata  <= {4'd0, code};
		s_tlast  <= last;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		account_word(code, last);
		words_sent++;
	endtask

	// Codes weighted toward the interpolated range and both ends of the code range.
	function automatic logic [11:0] draw_code();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel <= 5)
			return 12'($urandom_range(0, 4095));
		else if (sel <= 8)
			return 12'($urandom_range(344, 4095));
		else if ($urandom_range(0, 1) == 0)
			return 12'($urandom_range(0, 400));
		else
			return 12'($urandom_range(3900, 4095));
	endfunction

	task automatic report_mismatch(input string field, input int unsigned got,
		input int unsigned want);
		mismatch_count++;
		$display("mismatch on %s: got %0d, want %0d", field, got, want);
	endtask

	// Sends one frame of random codes in the given range.
	task automatic send_frame(input int len, input int lo, input int hi);
		for (int i = 0; i < len; i++)
			send_word(12'($urandom_range(lo, hi)), i == len - 1);
	endtask

	// Zero code, huge resistance, the upper table end and each segment boundary that a code can reach.
	task automatic test_table_edges();
		logic [11:0] codes [21];
		codes = '{12'd0, 12'd1, 12'd343, 12'd344, 12'd784, 12'd785, 12'd1369, 12'd1370,
			12'd2184, 12'd2185, 12'd3110, 12'd3111, 12'd3563, 12'd3564, 12'd3822,
			12'd3823, 12'd3989, 12'd3990, 12'hAAA, 12'h555, 12'd4095};
		gaps_on = 1'b1;
		for (int i = 0; i < 21; i++)
			send_word(codes[i], (i % 4 == 3) || (i == 20));
	endtask

	// Long frames of high codes drive the frame total into saturation.
	task automatic test_sum_saturation();
		for (int f = 0; f < 3; f++) begin
			gaps_on = (f != 1);
			send_frame($urandom_range(60, 72), 3900, 4095);
		end
		send_frame(3, 344, 4095);
	endtask

	// Random frames of mixed length with idling switched on and off in stretches.
	task automatic test_random_frames(input int unsigned target);
		int len;
		while (words_sent < target) begin
			if ($urandom_range(0, 5) == 0)
				gaps_on = !gaps_on;
			len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 16);
			for (int i = 0; i < len; i++)
				send_word(draw_code(), i == len - 1);
		end
	endtask

	// The receiver holds off for a long stretch while words keep coming.
	task automatic test_output_backpressure();
		gaps_on  = 1'b0;
		hold_req = 1'b1;
		send_frame(16, 0, 4095);
		gaps_on = 1'b1;
	endtask

	// Words back to back with no idling on either side.
	task automatic test_back_to_back();
		gaps_on = 1'b0;
		for (int i = 0; i < 150; i++)
			send_word(draw_code(), $urandom_range(0, 7) == 0 || i == 149);
		gaps_on = 1'b1;
	endtask

	// Stimulus sequence.
	initial begin
		arst_n         = 1'b0;
		s_tdata        = '0;
		s_tlast        = 1'b0;
		s_tvalid       = 1'b0;
		frame_sum      = '0;
		frame_hit_max  = 1'b0;
		mismatch_count = 0;
		words_sent     = 0;
		gaps_on        = 1'b1;
		hold_req       = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_table_edges();
		test_sum_saturation();
		test_output_backpressure();
		test_random_frames(1000);
		test_back_to_back();
		test_random_frames(1850);
		s_tvalid <= 1'b0;
		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// Receiver: random stalls per word while gaps are switched on, and one long hold when asked.
	initial begin
		int stall;
		m_tready = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			stall = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	// Compares each output word with the oldest expected word.
	always @(posedge clk) begin
		force_word_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_words.size() == 0) begin
				report_mismatch("unexpected word", m_tdata, 0);
			end else begin
				want = expected_words.pop_front();
				if (m_tdata[10:0] != want.grams)
					report_mismatch("force_grams", m_tdata[10:0], want.grams);
				if (m_tdata[11] != want.at_max)
					report_mismatch("force_at_max", m_tdata[11], want.at_max);
				if (m_tdata[27:12] != want.total)
					report_mismatch("frame_total", m_tdata[27:12], want.total);
				if (m_tdata[28] != want.total_max)
					report_mismatch("total_at_max", m_tdata[28], want.total_max);
				if (m_tdata[31:29] != 3'd0)
					report_mismatch("tdata padding", m_tdata[31:29], 0);
				if (m_tlast != want.total_valid)
					report_mismatch("total_valid", m_tlast, want.total_valid);
			end
		end
	end

	// Watchdog on cycles in which neither side moves a word.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule
